FILE: sv/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside reset.
`define CHK_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked during reset.
`define CHK_NEXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants of the butterfly counter.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 13;
  localparam int VALUE_W = 14;
  localparam int COUNT_W = 48;
  localparam int ECNT_W  = 32;
  localparam int VCNT_W  = 11;
  localparam int LAST_W  = 10;
  localparam int CFG_W   = 11;

  localparam logic [OP_W-1:0] OP_ROW    = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_LAST_START   = 1'b1;

  localparam logic [COUNT_W-1:0] TOTAL_MAX = {COUNT_W{1'b1}};
  localparam logic [ECNT_W-1:0]  ECNT_MAX  = {ECNT_W{1'b1}};

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_U_B, ST_U_E, ST_U_CAP,
    ST_A_LOOP, ST_A_V, ST_V_E, ST_V_CAP,
    ST_B_LOOP, ST_B_W, ST_B_C,
    ST_F_LOOP, ST_F_T, ST_F_C, ST_F_M,
    ST_DONE
  } state_t;

endpackage

FILE: sv/bipartite_butterfly_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_butterfly_counter
// Loads a graph in compressed-row form and counts butterflies by wedge
// aggregation into a per-endpoint count memory.
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// s_      | in  | tuser operation; tdata index, value
// m_      | out | tdata butterfly_count; tuser saturated
// cfg_    | in  | register writes, no handshake
//
// Load beats are accepted back to back while idle. A count walks the graph:
// it reads the row range of each start vertex and of each in-range
// neighbour v, skips out-of-range neighbours, skips or keeps each wedge, and
// folds each distinct endpoint in at the flush. After reset a clearing pass
// zeroes the endpoint counts; s_tready stays low meanwhile. The result sits
// in an output register; load beats are taken while it waits, but a second
// count holds s_tready low until the register frees.
module bipartite_butterfly_counter #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic [31:0] s_tdata,   // index[12:0], value[26:13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // butterfly_count[47:0]
  output logic        m_tuser,   // saturated
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [bbc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int RAW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = (EW > bbc_pkg::VALUE_W) ? EW : bbc_pkg::VALUE_W;
  localparam int CW  = 32;
  localparam int EC  = bbc_pkg::ECNT_W;

  // input fields
  logic [bbc_pkg::OP_W-1:0]    operation;
  logic [bbc_pkg::INDEX_W-1:0] index;
  logic [bbc_pkg::VALUE_W-1:0] value;
  assign operation = s_tuser;
  assign index     = s_tdata[12:0];
  assign value     = s_tdata[26:13];

  logic [bbc_pkg::VCNT_W-1:0] vertex_count;
  logic [bbc_pkg::LAST_W-1:0] last_start_vertex;

  bbc_pkg::state_t state, state_next;

  logic [VW:0]    n, k, touched, clr;
  logic [VW-1:0]  u, v, lim, wreg, last;
  logic [AW-1:0]  begin_off, a, b, ue, ve;
  logic [2*EC-1:0] prod;
  logic [bbc_pkg::COUNT_W-1:0] acc, res_count;
  logic sat, res_sat;

  // memory ports
  logic                        row_we, nbr_we, cnt_we, tch_we;
  logic [RAW-1:0]              row_raddr;
  logic [bbc_pkg::VALUE_W-1:0] row_rdata, nbr_rdata;
  logic [EAW-1:0]              nbr_raddr;
  logic [VW-1:0]               cnt_waddr, cnt_raddr;
  logic [EC-1:0]               cnt_wdata, cnt_rdata;
  logic [VW-1:0]               tch_raddr, tch_rdata;

  logic accept;
  logic [AW-1:0] row_end;
  logic [VW:0]   n_cfg;
  logic [2*EC-1:0] tri_val;

  assign s_tready = (state == bbc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // end offsets above the edge table clip to its size
  assign row_end = (CW'(row_rdata) > CW'(MAX_EDGES)) ? AW'(MAX_EDGES) : AW'(row_rdata);
  assign n_cfg   = (CW'(vertex_count) > CW'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES)
                                                            : (VW+1)'(vertex_count);
  assign tri_val = prod >> 1;

  bbc_ram #(.WIDTH(bbc_pkg::VALUE_W), .DEPTH(MAX_VERTICES + 1)) u_row (
    .clk(clk), .we(row_we), .waddr(RAW'(index)), .wdata(value),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  bbc_ram #(.WIDTH(bbc_pkg::VALUE_W), .DEPTH(MAX_EDGES)) u_nbr (
    .clk(clk), .we(nbr_we), .waddr(EAW'(index)), .wdata(value),
    .raddr(nbr_raddr), .rdata(nbr_rdata)
  );

  bbc_ram #(.WIDTH(EC), .DEPTH(MAX_VERTICES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  bbc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_tch (
    .clk(clk), .we(tch_we), .waddr(VW'(touched)), .wdata(wreg),
    .raddr(tch_raddr), .rdata(tch_rdata)
  );

  always_comb begin
    state_next = state;
    row_we     = 1'b0;
    nbr_we     = 1'b0;
    cnt_we     = 1'b0;
    tch_we     = 1'b0;
    row_raddr  = RAW'(u);
    nbr_raddr  = EAW'(b);
    cnt_raddr  = VW'(nbr_rdata);
    cnt_waddr  = wreg;
    cnt_wdata  = '0;
    tch_raddr  = VW'(k);
    case (state)
      bbc_pkg::ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = VW'(clr);
        if (CW'(clr) == CW'(MAX_VERTICES - 1)) begin
          state_next = bbc_pkg::ST_IDLE;
        end
      end
      bbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation)
            bbc_pkg::OP_ROW:  row_we = (CW'(index) <= CW'(MAX_VERTICES));
            bbc_pkg::OP_EDGE: nbr_we = (CW'(index) < CW'(MAX_EDGES));
            bbc_pkg::OP_COUNT: begin
              state_next = (n_cfg == '0) ? bbc_pkg::ST_DONE : bbc_pkg::ST_U_B;
            end
            default: ;
          endcase
        end
      end
      bbc_pkg::ST_U_B:   state_next = bbc_pkg::ST_U_E;
      bbc_pkg::ST_U_E: begin
        row_raddr  = RAW'(u) + RAW'(1);
        state_next = bbc_pkg::ST_U_CAP;
      end
      bbc_pkg::ST_U_CAP: state_next = bbc_pkg::ST_A_LOOP;
      bbc_pkg::ST_A_LOOP: begin
        nbr_raddr  = EAW'(a);
        state_next = (a >= ue) ? bbc_pkg::ST_F_LOOP : bbc_pkg::ST_A_V;
      end
      bbc_pkg::ST_A_V: begin
        row_raddr  = RAW'(nbr_rdata);
        state_next = (CW'(nbr_rdata) >= CW'(n)) ? bbc_pkg::ST_A_LOOP : bbc_pkg::ST_V_E;
      end
      bbc_pkg::ST_V_E: begin
        row_raddr  = RAW'(v) + RAW'(1);
        state_next = bbc_pkg::ST_V_CAP;
      end
      bbc_pkg::ST_V_CAP: state_next = bbc_pkg::ST_B_LOOP;
      bbc_pkg::ST_B_LOOP: begin
        state_next = (b >= ve) ? bbc_pkg::ST_A_LOOP : bbc_pkg::ST_B_W;
      end
      bbc_pkg::ST_B_W: begin
        state_next = (CW'(nbr_rdata) >= CW'(lim)) ? bbc_pkg::ST_B_LOOP : bbc_pkg::ST_B_C;
      end
      bbc_pkg::ST_B_C: begin
        // first hit of an endpoint goes on the touched list
        tch_we     = (cnt_rdata == '0);
        cnt_we     = (cnt_rdata != bbc_pkg::ECNT_MAX);
        cnt_wdata  = cnt_rdata + EC'(1);
        state_next = bbc_pkg::ST_B_LOOP;
      end
      bbc_pkg::ST_F_LOOP: begin
        if (k >= touched) begin
          state_next = (u == last) ? bbc_pkg::ST_DONE : bbc_pkg::ST_U_B;
        end else begin
          state_next = bbc_pkg::ST_F_T;
        end
      end
      bbc_pkg::ST_F_T: begin
        cnt_raddr  = tch_rdata;
        state_next = bbc_pkg::ST_F_C;
      end
      bbc_pkg::ST_F_C: begin
        cnt_we     = 1'b1;
        state_next = bbc_pkg::ST_F_M;
      end
      bbc_pkg::ST_F_M:   state_next = bbc_pkg::ST_F_LOOP;
      bbc_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = bbc_pkg::ST_IDLE;
        end
      end
      default: state_next = bbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= bbc_pkg::ST_CLR;
      clr               <= '0;
      vertex_count      <= bbc_pkg::VCNT_W'(1024);
      last_start_vertex <= bbc_pkg::LAST_W'(1023);
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == bbc_pkg::CFG_VERTEX_COUNT) begin
          vertex_count <= cfg_wdata;
        end else begin
          last_start_vertex <= cfg_wdata[bbc_pkg::LAST_W-1:0];
        end
      end
      if (state == bbc_pkg::ST_CLR) begin
        clr <= clr + 1'b1;
      end
      if (state == bbc_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bbc_pkg::ST_IDLE: begin
        n       <= n_cfg;
        last    <= (CW'(last_start_vertex) > CW'(n_cfg) - 1) ? VW'(n_cfg - 1'b1)
                                                              : VW'(last_start_vertex);
        u       <= '0;
        acc     <= '0;
        sat     <= 1'b0;
        touched <= '0;
      end
      bbc_pkg::ST_U_E:   begin_off <= AW'(row_rdata);
      bbc_pkg::ST_U_CAP: begin
        ue <= row_end;
        a  <= begin_off;
        k  <= '0;
      end
      bbc_pkg::ST_A_V: begin
        v   <= VW'(nbr_rdata);
        lim <= (CW'(nbr_rdata) < CW'(u)) ? VW'(nbr_rdata) : u;
        if (CW'(nbr_rdata) >= CW'(n)) begin
          a <= a + 1'b1;
        end
      end
      bbc_pkg::ST_V_E:   begin_off <= AW'(row_rdata);
      bbc_pkg::ST_V_CAP: begin
        ve <= row_end;
        b  <= begin_off;
      end
      bbc_pkg::ST_B_LOOP: begin
        if (b >= ve) begin
          a <= a + 1'b1;
        end
      end
      bbc_pkg::ST_B_W: begin
        wreg <= VW'(nbr_rdata);
        if (CW'(nbr_rdata) >= CW'(lim)) begin
          b <= b + 1'b1;
        end
      end
      bbc_pkg::ST_B_C: begin
        b <= b + 1'b1;
        if (cnt_rdata == '0) begin
          touched <= touched + 1'b1;
        end
        if (cnt_rdata == bbc_pkg::ECNT_MAX) begin
          sat <= 1'b1;
        end
      end
      bbc_pkg::ST_F_LOOP: begin
        if (k >= touched) begin
          touched <= '0;
          u       <= u + 1'b1;
        end
      end
      bbc_pkg::ST_F_T: wreg <= tch_rdata;
      bbc_pkg::ST_F_C: prod <= (2*EC)'(cnt_rdata) * (2*EC)'(cnt_rdata - EC'(1));
      bbc_pkg::ST_F_M: begin
        k <= k + 1'b1;
        if (tri_val > (2*EC)'(bbc_pkg::TOTAL_MAX - acc)) begin
          acc <= bbc_pkg::TOTAL_MAX;
          sat <= 1'b1;
        end else begin
          acc <= acc + bbc_pkg::COUNT_W'(tri_val);
        end
      end
      bbc_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          res_count <= acc;
          res_sat   <= sat;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = res_count;
  assign m_tuser = res_sat;

endmodule

FILE: sv/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bbc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bbc_port_checker
// Port-level checks of the butterfly counter.
// ----------------------------------------------------------------------------
module bbc_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  logic        m_stall;
  logic [48:0] m_beat;
  assign m_stall = m_tvalid && !m_tready;
  assign m_beat  = {m_tuser, m_tdata};

  `CHK_NEXT(a_rst_idle, clk, rst, !m_tvalid)
  `CHK_IMPLY(a_hold, clk, rst, $past(m_stall) && !$past(rst), m_tvalid && $stable(m_beat))
  `CHK_IMPLY(a_result_after_busy, clk, rst, $rose(m_tvalid), $past(!s_tready))
  `CHK_IMPLY(a_sat_full, clk, rst, m_tvalid && m_tuser, &m_tdata)

endmodule

bind bipartite_butterfly_counter bbc_port_checker u_port_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: dv/bbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_checker
// Watches the load/count stream, the register port and the result stream of
// the butterfly counter. It mirrors the loaded graph and registers, predicts
// the butterfly total of each count beat, and compares the result beats in
// order.
// ----------------------------------------------------------------------------
module bbc_checker #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [1:0]        s_tuser,   // operation[1:0]
  input  logic [31:0]       s_tdata,   // index[12:0], value[26:13]
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [47:0]       m_tdata,   // butterfly_count[47:0]
  input  logic              m_tuser,   // saturated
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [bbc_pkg::CFG_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [bbc_pkg::COUNT_W-1:0] total;
    logic                        sat;
  } tally_t;

  logic [bbc_pkg::VALUE_W-1:0] row_start [0:MAX_VERTICES];
  logic [bbc_pkg::VALUE_W-1:0] adj_list  [0:MAX_EDGES-1];
  longint unsigned             hits      [0:MAX_VERTICES-1];
  logic [bbc_pkg::VCNT_W-1:0]  vtx_count;
  logic [bbc_pkg::LAST_W-1:0]  last_start;
  tally_t                      tally_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    foreach (row_start[i]) row_start[i] = '0;
    foreach (adj_list[i]) adj_list[i] = '0;
    foreach (hits[i]) hits[i] = 0;
  end

  function automatic int unsigned row_end(int unsigned vtx);
    int unsigned e;
    e = row_start[vtx + 1];
    return (e > MAX_EDGES) ? MAX_EDGES : e;
  endfunction

  function automatic tally_t count_butterflies();
    tally_t          r;
    int unsigned     n, last, u, a, b, ue, ve, v, w, lim, k, ntouch;
    int unsigned     touched [MAX_VERTICES];
    longint unsigned c, t, acc;
    r.sat = 1'b0;
    acc = 0;
    n = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
    if (n != 0) begin
      last = (last_start > n - 1) ? n - 1 : last_start;
      for (u = 0; u <= last; u++) begin
        ntouch = 0;
        ue = row_end(u);
        for (a = row_start[u]; a < ue; a++) begin
          v = adj_list[a];
          if (v >= n) continue;
          lim = (v < u) ? v : u;
          ve = row_end(v);
          for (b = row_start[v]; b < ve; b++) begin
            w = adj_list[b];
            if (w >= lim) continue;
            if (hits[w] == 0) begin
              touched[ntouch] = w;
              ntouch++;
            end
            if (hits[w] == bbc_pkg::ECNT_MAX) r.sat = 1'b1;
            else hits[w]++;
          end
        end
        // fold wedge counts of this start vertex, then clear them
        for (k = 0; k < ntouch; k++) begin
          c = hits[touched[k]];
          t = c * (c - 1) / 2;
          if (t > bbc_pkg::TOTAL_MAX - acc) begin
            acc = bbc_pkg::TOTAL_MAX;
            r.sat = 1'b1;
          end else begin
            acc += t;
          end
          hits[touched[k]] = 0;
        end
      end
    end
    r.total = acc[bbc_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [bbc_pkg::OP_W-1:0]    op;
    logic [bbc_pkg::INDEX_W-1:0] idx;
    logic [bbc_pkg::VALUE_W-1:0] val;
    tally_t                      want;
    if (rst) begin
      vtx_count  = 11'd1024;
      last_start = 10'd1023;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bbc_pkg::CFG_VERTEX_COUNT) begin
          vtx_count = cfg_wdata[bbc_pkg::VCNT_W-1:0];
        end else begin
          last_start = cfg_wdata[bbc_pkg::LAST_W-1:0];
        end
      end
      if (s_tvalid && s_tready) begin
        op  = s_tuser;
        idx = s_tdata[12:0];
        val = s_tdata[26:13];
        if (op == bbc_pkg::OP_ROW) begin
          if (idx <= MAX_VERTICES) row_start[idx] = val;
        end else if (op == bbc_pkg::OP_EDGE) begin
          if (idx < MAX_EDGES) adj_list[idx] = val;
        end else if (op == bbc_pkg::OP_COUNT) begin
          tally_q.insert(tally_q.size(), count_butterflies());
        end
      end
      if (m_tvalid && m_tready) begin
        if (tally_q.size() == 0) begin
          report("unexpected result beat, count", m_tdata, 0);
        end else begin
          want = tally_q.pop_front();
          if (m_tdata !== want.total) report("butterfly_count", m_tdata, want.total);
          if (m_tuser !== want.sat) report("saturated", m_tuser, want.sat);
        end
      end
    end
    pending <= tally_q.size();
  end

endmodule

FILE: dv/tb_bipartite_butterfly_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bipartite_butterfly_counter
// Loads small compressed-row graphs with random content under bursty input
// and a stalling result side, starts counts across several register
// settings, and lets the checker compare every total.
// ----------------------------------------------------------------------------
module tb_bipartite_butterfly_counter;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int ITEM_TARGET  = 1100;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [1:0]                s_tuser = '0;   // operation[1:0]
  logic [31:0]               s_tdata = '0;   // index[12:0], value[26:13]
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [47:0]               m_tdata;        // butterfly_count[47:0]
  logic                      m_tuser;        // saturated
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = bbc_pkg::CFG_VERTEX_COUNT;
  logic [bbc_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_count, pending;
  int beats_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   mode = 0;
  int   mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bipartite_butterfly_counter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bbc_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // result side: one long hold on request, otherwise shifting stall modes
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 400;
      m_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 2);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_beat(input logic [bbc_pkg::OP_W-1:0] op, input int unsigned idx,
                           input int unsigned val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b00000, val[bbc_pkg::VALUE_W-1:0], idx[bbc_pkg::INDEX_W-1:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic write_reg(input logic which, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= val[bbc_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all totals, then give the block time to settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Ids are either real vertices below k or at/above the effective vertex
  // count, so a count never reads a row that was not loaded.
  task automatic load_graph(input int k, input int nedges, input int n_eff);
    int offs[$];
    int j;
    for (j = 0; j <= k; j++) offs.insert(offs.size(), $urandom_range(0, nedges));
    if ($urandom_range(0, 4) != 0) offs.sort();
    for (j = 0; j <= k; j++) send_beat(bbc_pkg::OP_ROW, j, offs[j]);
    for (j = 0; j < nedges; j++) begin
      if ($urandom_range(0, 6) != 0 || n_eff > 16383) begin
        send_beat(bbc_pkg::OP_EDGE, j, $urandom_range(0, k - 1));
      end else begin
        send_beat(bbc_pkg::OP_EDGE, j, $urandom_range(n_eff, 16383));
      end
    end
  endtask

  task automatic send_noise();
    int j;
    for (j = $urandom_range(0, 3); j > 0; j--) begin
      case ($urandom_range(0, 2))
        0: send_beat(bbc_pkg::OP_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 16383));
        1: send_beat(bbc_pkg::OP_ROW, $urandom_range(0, 8191), $urandom_range(0, 16383));
        default: send_beat(bbc_pkg::OP_EDGE, $urandom_range(0, 8191),
                           $urandom_range(0, 16383));
      endcase
    end
  endtask

  initial begin
    int k, n, n_eff, last, j;
    int adj [8] = '{2, 3, 2, 3, 0, 1, 0, 1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one square: left 0,1 and right 2,3, plus beats the square never reads
    write_reg(bbc_pkg::CFG_VERTEX_COUNT, 4);
    write_reg(bbc_pkg::CFG_LAST_START, 3);
    send_beat(bbc_pkg::OP_UNUSED, 8191, 16383);
    send_beat(bbc_pkg::OP_ROW, 1025, 16383);
    send_beat(bbc_pkg::OP_ROW, 8191, 8192);
    send_beat(bbc_pkg::OP_EDGE, 8191, 16383);
    for (j = 0; j <= 4; j++) send_beat(bbc_pkg::OP_ROW, j, 2 * j);
    for (j = 0; j < 8; j++) send_beat(bbc_pkg::OP_EDGE, j, adj[j]);
    send_beat(bbc_pkg::OP_COUNT, 0, 0);
    drain();

    // oversized vertex count acts as the maximum
    write_reg(bbc_pkg::CFG_VERTEX_COUNT, 2047);
    send_beat(bbc_pkg::OP_COUNT, 8191, 16383);
    drain();

    // no vertices
    write_reg(bbc_pkg::CFG_VERTEX_COUNT, 0);
    send_beat(bbc_pkg::OP_COUNT, 0, 0);
    drain();

    // single vertex whose range lies past the edge table
    write_reg(bbc_pkg::CFG_VERTEX_COUNT, 1);
    write_reg(bbc_pkg::CFG_LAST_START, 0);
    send_beat(bbc_pkg::OP_ROW, 0, 8500);
    send_beat(bbc_pkg::OP_ROW, 1, 16383);
    send_beat(bbc_pkg::OP_COUNT, 0, 0);
    drain();

    // last start clipped; result side held off while two counts queue up
    write_reg(bbc_pkg::CFG_VERTEX_COUNT, 8);
    write_reg(bbc_pkg::CFG_LAST_START, 1023);
    hold_req = 1'b1;
    load_graph(8, 24, 8);
    send_beat(bbc_pkg::OP_COUNT, 0, 0);
    send_beat(bbc_pkg::OP_COUNT, 0, 0);
    drain();

    while (beats_sent < ITEM_TARGET) begin
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(2, 12);
      case ($urandom_range(0, 6))
        0: n = 1024;
        1: n = $urandom_range(1025, 2047);
        2: n = k;
        default: n = $urandom_range(1, k);
      endcase
      n_eff = (n > 1024) ? 1024 : n;
      if (n_eff > k) last = $urandom_range(0, k - 1);
      else if ($urandom_range(0, 1) == 0) last = $urandom_range(0, 1023);
      else last = $urandom_range(0, n_eff - 1);
      write_reg(bbc_pkg::CFG_VERTEX_COUNT, n);
      write_reg(bbc_pkg::CFG_LAST_START, last);
      send_noise();
      load_graph(k, $urandom_range(0, 4 * k), n_eff);
      send_beat(bbc_pkg::OP_COUNT, $urandom_range(0, 8191), $urandom_range(0, 16383));
      if ($urandom_range(0, 3) == 0) send_beat(bbc_pkg::OP_COUNT, 0, 0);
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bipartite_butterfly_counter.sv
sv/bbc_checker.sv
dv/bbc_checker.sv
dv/tb_bipartite_butterfly_counter.sv
